// ===== rtl/oibe_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, constants and byte helpers for the object image block emitter.
// Depends on nothing; every other file uses it by scoped names.
package oibe_pkg;

  localparam int ADDR_W     = 12;
  localparam int WORD_W     = 12;
  localparam int BYTE_W     = 8;
  localparam int NWORDS_W   = 7;
  localparam int BIDX_W     = 8;
  localparam int HDR_W      = 32;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 32;

  localparam int DEF_MEMORY_WORDS    = 4096;
  localparam int DEF_MAX_BLOCK_WORDS = 126;
  localparam int DEF_HEADER_LENGTH   = 4;

  typedef enum logic [1:0] {
    ACT_CLEAR  = 2'd0,
    ACT_DEFINE = 2'd1,
    ACT_FETCH  = 2'd2,
    ACT_PULL   = 2'd3
  } action_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ENTRY_ADDRESS = 1'd0,
    REG_HEADER_BYTES  = 1'd1
  } cfg_reg_t;

  // One store entry: the defined mark travels with the word.
  typedef struct packed {
    logic              defined;
    logic [WORD_W-1:0] word;
  } store_word_t;

  function automatic logic [BYTE_W-1:0] upper6(input logic [WORD_W-1:0] v);
    upper6 = {2'b00, v[11:6]};
  endfunction

  function automatic logic [BYTE_W-1:0] lower6(input logic [WORD_W-1:0] v);
    lower6 = {2'b00, v[5:0]};
  endfunction

endpackage

// ===== rtl/oibe_if.sv =====
`timescale 1ns / 1ps
// Channel interfaces of the object image block emitter: request, result, config.
// Depends on oibe_pkg for field widths.
interface oibe_in_if;
  logic                          valid;
  logic                          ready;
  logic [1:0]                    action;
  logic [oibe_pkg::ADDR_W-1:0]   address;
  logic [oibe_pkg::WORD_W-1:0]   word_value;
  logic                          allow_redefine;
  modport source (output valid, action, address, word_value, allow_redefine, input ready);
  modport sink   (input valid, action, address, word_value, allow_redefine, output ready);
endinterface

interface oibe_out_if;
  logic                          valid;
  logic                          ready;
  logic [oibe_pkg::WORD_W-1:0]   read_word;
  logic                          redefined_error;
  logic [oibe_pkg::BYTE_W-1:0]   out_byte;
  logic                          out_valid;
  logic                          image_last;
  modport source (output valid, read_word, redefined_error, out_byte, out_valid, image_last,
                  input ready);
  modport sink   (input valid, read_word, redefined_error, out_byte, out_valid, image_last,
                  output ready);
endinterface

interface oibe_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [oibe_pkg::CFG_IDX_W-1:0]    index;
  logic [oibe_pkg::CFG_DATA_W-1:0]   data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/oibe_store.sv =====
`timescale 1ns / 1ps
// Word store with defined marks: one write port, one registered read port.
// Depends on oibe_pkg for the entry type.
module oibe_store #(
  parameter int WORDS = oibe_pkg::DEF_MEMORY_WORDS,
  localparam int AW   = $clog2(WORDS)
) (
  input  logic                  clk,
  input  logic                  we,
  input  logic [AW-1:0]         waddr,
  input  oibe_pkg::store_word_t wdata,
  input  logic [AW-1:0]         raddr,
  output oibe_pkg::store_word_t rdata
);

  oibe_pkg::store_word_t mem [WORDS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/object_image_block_emitter.sv =====
`timescale 1ns / 1ps
// Object image block emitter: word store with defined marks plus a byte-wise image serializer.
// Depends on oibe_pkg, the oibe_*_if interfaces and oibe_store.
//
// The block holds MEMORY_WORDS 12-bit words, each with a defined mark, in one
// single-port-write, registered-read memory; the mark lives in the same entry as
// the word. Requests come one word at a time and each gives exactly one result
// word. Define and fetch read the entry, check/write, then load the output register;
// a pull that only steps the header, entry, size or address bytes loads its byte
// straight into the output register; a pull of a data byte reads the entry first;
// a pull that closes a block (or the lower entry byte) also searches for the next
// run, reading and checking each address visited. Clear sweeps every entry once.
// After reset the same sweep runs with in.ready low; config writes are taken at
// any time. The request side is not ready while an item is in progress, but it is
// ready while a finished result waits in the output register. The run search and
// the data walk share one address counter and incrementer.
module object_image_block_emitter #(
  parameter int MEMORY_WORDS    = oibe_pkg::DEF_MEMORY_WORDS,
  parameter int MAX_BLOCK_WORDS = oibe_pkg::DEF_MAX_BLOCK_WORDS,
  parameter int HEADER_LENGTH   = oibe_pkg::DEF_HEADER_LENGTH
) (
  input logic        clk,
  input logic        rst_n,
  oibe_in_if.sink    in_port,
  oibe_out_if.source out_port,
  oibe_cfg_if.sink   cfg_port
);

  localparam int AW = $clog2(MEMORY_WORDS);
  localparam int CW = AW + 1;
  localparam logic [CW-1:0] CUR_END  = CW'(MEMORY_WORDS);
  localparam logic [CW-1:0] CUR_LAST = CW'(MEMORY_WORDS - 1);
  localparam logic [oibe_pkg::ADDR_W:0] ADDR_END = (oibe_pkg::ADDR_W + 1)'(MEMORY_WORDS);
  localparam logic [oibe_pkg::NWORDS_W-1:0] RUN_MAX = oibe_pkg::NWORDS_W'(MAX_BLOCK_WORDS);
  localparam logic [oibe_pkg::BIDX_W-1:0]   HDR_LEN = oibe_pkg::BIDX_W'(HEADER_LENGTH);

  // sequencer
  typedef enum logic [8:0] {
    S_IDLE     = 9'b000000001,
    S_CLR      = 9'b000000010,
    S_MRD      = 9'b000000100,
    S_MCHK     = 9'b000001000,
    S_SKIP_RD  = 9'b000010000,
    S_SKIP_CHK = 9'b000100000,
    S_RUN_RD   = 9'b001000000,
    S_RUN_CHK  = 9'b010000000,
    S_RESP     = 9'b100000000
  } state_t;

  // image phase
  typedef enum logic [7:0] {
    PH_HEADER   = 8'b00000001,
    PH_ENTRY_HI = 8'b00000010,
    PH_ENTRY_LO = 8'b00000100,
    PH_SIZE     = 8'b00001000,
    PH_ADDR_HI  = 8'b00010000,
    PH_ADDR_LO  = 8'b00100000,
    PH_DATA     = 8'b01000000,
    PH_DONE     = 8'b10000000
  } phase_t;

  state_t state_r, state_nxt;
  phase_t phase_r, phase_nxt;
  logic   boot_r, boot_nxt;

  // captured request
  oibe_pkg::action_t                act_r, act_nxt;
  logic [oibe_pkg::ADDR_W-1:0]      addr_r, addr_nxt;
  logic [oibe_pkg::WORD_W-1:0]      val_r, val_nxt;
  logic                             allow_r, allow_nxt;

  // image walk: one counter serves the run search, the data walk and the clear sweep
  logic [CW-1:0]                    cursor_r, cursor_nxt;
  logic [AW-1:0]                    blk_start_r, blk_start_nxt;
  logic [oibe_pkg::NWORDS_W-1:0]    blk_words_r, blk_words_nxt;
  logic [oibe_pkg::BIDX_W-1:0]      byte_idx_r, byte_idx_nxt;

  // config registers
  logic [oibe_pkg::ADDR_W-1:0]      entry_r, entry_nxt;
  logic [oibe_pkg::HDR_W-1:0]       header_r, header_nxt;

  // result being built
  logic [oibe_pkg::WORD_W-1:0]      res_rd_r, res_rd_nxt;
  logic                             res_err_r, res_err_nxt;
  logic [oibe_pkg::BYTE_W-1:0]      res_byte_r, res_byte_nxt;
  logic                             res_ov_r, res_ov_nxt;
  logic                             res_last_r, res_last_nxt;

  // output register
  logic                             ovld_r, ovld_nxt;
  logic [oibe_pkg::WORD_W-1:0]      o_rd_r, o_rd_nxt;
  logic                             o_err_r, o_err_nxt;
  logic [oibe_pkg::BYTE_W-1:0]      o_byte_r, o_byte_nxt;
  logic                             o_ov_r, o_ov_nxt;
  logic                             o_last_r, o_last_nxt;

  // memory port
  logic                             mem_we;
  logic [AW-1:0]                    mem_waddr;
  oibe_pkg::store_word_t            mem_wdata;
  logic [AW-1:0]                    mem_raddr;
  oibe_pkg::store_word_t            mem_rdata;

  logic                             in_acc;
  logic                             req_oob;
  logic [oibe_pkg::WORD_W-1:0]      rd_word;
  logic [oibe_pkg::WORD_W-1:0]      start_ext;
  logic [1:0]                       hdr_pos;
  logic [oibe_pkg::BIDX_W:0]        bidx_inc;

  oibe_store #(
    .WORDS (MEMORY_WORDS)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  assign in_port.ready  = (state_r == S_IDLE);
  assign in_acc         = in_port.valid && in_port.ready;
  assign cfg_port.ready = 1'b1;

  assign out_port.valid           = ovld_r;
  assign out_port.read_word       = o_rd_r;
  assign out_port.redefined_error = o_err_r;
  assign out_port.out_byte        = o_byte_r;
  assign out_port.out_valid       = o_ov_r;
  assign out_port.image_last      = o_last_r;

  assign req_oob   = ({1'b0, in_port.address} >= ADDR_END);
  assign rd_word   = mem_rdata.defined ? mem_rdata.word : '0;
  assign start_ext = oibe_pkg::WORD_W'(blk_start_r);
  // header byte k sits at byte lane HEADER_LENGTH-1-k
  assign hdr_pos   = 2'(HEADER_LENGTH - 1 - int'(byte_idx_r[1:0]));
  assign bidx_inc  = {1'b0, byte_idx_r} + 1'b1;

  always_comb begin
    state_nxt     = state_r;
    phase_nxt     = phase_r;
    boot_nxt      = boot_r;
    act_nxt       = act_r;
    addr_nxt      = addr_r;
    val_nxt       = val_r;
    allow_nxt     = allow_r;
    cursor_nxt    = cursor_r;
    blk_start_nxt = blk_start_r;
    blk_words_nxt = blk_words_r;
    byte_idx_nxt  = byte_idx_r;
    entry_nxt     = entry_r;
    header_nxt    = header_r;
    res_rd_nxt    = res_rd_r;
    res_err_nxt   = res_err_r;
    res_byte_nxt  = res_byte_r;
    res_ov_nxt    = res_ov_r;
    res_last_nxt  = res_last_r;
    ovld_nxt      = ovld_r;
    o_rd_nxt      = o_rd_r;
    o_err_nxt     = o_err_r;
    o_byte_nxt    = o_byte_r;
    o_ov_nxt      = o_ov_r;
    o_last_nxt    = o_last_r;
    mem_we        = 1'b0;
    mem_waddr     = cursor_r[AW-1:0];
    mem_wdata     = '{defined: 1'b0, word: val_r};
    mem_raddr     = cursor_r[AW-1:0];

    if (cfg_port.valid) begin
      unique case (oibe_pkg::cfg_reg_t'(cfg_port.index))
        oibe_pkg::REG_ENTRY_ADDRESS: entry_nxt  = cfg_port.data[oibe_pkg::ADDR_W-1:0];
        oibe_pkg::REG_HEADER_BYTES:  header_nxt = cfg_port.data[oibe_pkg::HDR_W-1:0];
        default: ;
      endcase
    end

    if (ovld_r && out_port.ready) begin
      ovld_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          act_nxt      = oibe_pkg::action_t'(in_port.action);
          addr_nxt     = in_port.address;
          val_nxt      = in_port.word_value;
          allow_nxt    = in_port.allow_redefine;
          res_rd_nxt   = '0;
          res_err_nxt  = 1'b0;
          res_byte_nxt = '0;
          res_ov_nxt   = 1'b0;
          res_last_nxt = 1'b0;
          unique case (oibe_pkg::action_t'(in_port.action))
            oibe_pkg::ACT_CLEAR: begin
              phase_nxt     = PH_HEADER;
              byte_idx_nxt  = '0;
              blk_start_nxt = '0;
              blk_words_nxt = '0;
              cursor_nxt    = '0;
              state_nxt     = S_CLR;
            end
            oibe_pkg::ACT_DEFINE, oibe_pkg::ACT_FETCH: begin
              state_nxt = req_oob ? S_RESP : S_MRD;
            end
            oibe_pkg::ACT_PULL: begin
              res_ov_nxt = 1'b1;
              state_nxt  = S_RESP;
              unique case (phase_r)
                PH_HEADER: begin
                  if (byte_idx_r >= HDR_LEN) begin
                    // header already used up: this pull is the upper entry byte
                    res_byte_nxt = oibe_pkg::upper6(entry_r);
                    phase_nxt    = PH_ENTRY_LO;
                  end else begin
                    res_byte_nxt = header_r[{hdr_pos, 3'b000} +: 8];
                    if (bidx_inc >= {1'b0, HDR_LEN}) begin
                      phase_nxt    = PH_ENTRY_HI;
                      byte_idx_nxt = '0;
                    end else begin
                      byte_idx_nxt = bidx_inc[oibe_pkg::BIDX_W-1:0];
                    end
                  end
                end
                PH_ENTRY_HI: begin
                  res_byte_nxt = oibe_pkg::upper6(entry_r);
                  phase_nxt    = PH_ENTRY_LO;
                end
                PH_ENTRY_LO: begin
                  res_byte_nxt = oibe_pkg::lower6(entry_r);
                  cursor_nxt   = '0;
                  state_nxt    = S_SKIP_RD;
                end
                PH_SIZE: begin
                  res_byte_nxt = {blk_words_r, 1'b0} + oibe_pkg::BYTE_W'(3);
                  phase_nxt    = PH_ADDR_HI;
                end
                PH_ADDR_HI: begin
                  res_byte_nxt = oibe_pkg::upper6(start_ext);
                  phase_nxt    = PH_ADDR_LO;
                end
                PH_ADDR_LO: begin
                  res_byte_nxt = oibe_pkg::lower6(start_ext);
                  byte_idx_nxt = '0;
                  cursor_nxt   = {1'b0, blk_start_r};
                  phase_nxt    = PH_DATA;
                end
                PH_DATA: begin
                  state_nxt = S_MRD;
                end
                PH_DONE: begin
                  res_ov_nxt = 1'b0;
                end
                default: ;
              endcase
            end
            default: ;
          endcase
        end
      end

      S_CLR: begin
        mem_we     = 1'b1;
        mem_wdata  = '{defined: 1'b0, word: val_r};
        cursor_nxt = cursor_r + 1'b1;
        if (cursor_r == CUR_LAST) begin
          cursor_nxt = '0;
          if (boot_r) begin
            boot_nxt  = 1'b0;
            state_nxt = S_IDLE;
          end else begin
            state_nxt = S_RESP;
          end
        end
      end

      S_MRD: begin
        mem_raddr = (act_r == oibe_pkg::ACT_PULL) ? cursor_r[AW-1:0] : addr_r[AW-1:0];
        state_nxt = S_MCHK;
      end

      S_MCHK: begin
        unique case (act_r)
          oibe_pkg::ACT_DEFINE: begin
            res_err_nxt = mem_rdata.defined && !allow_r;
            mem_we      = 1'b1;
            mem_waddr   = addr_r[AW-1:0];
            mem_wdata   = '{defined: 1'b1, word: val_r};
            state_nxt   = S_RESP;
          end
          oibe_pkg::ACT_FETCH: begin
            res_rd_nxt = rd_word;
            state_nxt  = S_RESP;
          end
          oibe_pkg::ACT_CLEAR, oibe_pkg::ACT_PULL: begin
            res_byte_nxt = byte_idx_r[0] ? oibe_pkg::lower6(rd_word)
                                         : oibe_pkg::upper6(rd_word);
            byte_idx_nxt = bidx_inc[oibe_pkg::BIDX_W-1:0];
            if (byte_idx_r[0]) begin
              cursor_nxt = cursor_r + 1'b1;
            end
            if (bidx_inc >= {1'b0, blk_words_r, 1'b0}) begin
              // block done; cursor now sits just past it
              byte_idx_nxt = '0;
              state_nxt    = S_SKIP_RD;
            end else begin
              state_nxt = S_RESP;
            end
          end
          default: state_nxt = S_RESP;
        endcase
      end

      S_SKIP_RD: begin
        if (cursor_r >= CUR_END) begin
          phase_nxt    = PH_DONE;
          res_last_nxt = 1'b1;
          state_nxt    = S_RESP;
        end else begin
          state_nxt = S_SKIP_CHK;
        end
      end

      S_SKIP_CHK: begin
        cursor_nxt = cursor_r + 1'b1;
        if (mem_rdata.defined) begin
          blk_start_nxt = cursor_r[AW-1:0];
          blk_words_nxt = oibe_pkg::NWORDS_W'(1);
          state_nxt     = S_RUN_RD;
        end else begin
          state_nxt = S_SKIP_RD;
        end
      end

      S_RUN_RD: begin
        if ((blk_words_r < RUN_MAX) && (cursor_r < CUR_END)) begin
          state_nxt = S_RUN_CHK;
        end else begin
          phase_nxt = PH_SIZE;
          state_nxt = S_RESP;
        end
      end

      S_RUN_CHK: begin
        if (mem_rdata.defined) begin
          blk_words_nxt = blk_words_r + 1'b1;
          cursor_nxt    = cursor_r + 1'b1;
          state_nxt     = S_RUN_RD;
        end else begin
          phase_nxt = PH_SIZE;
          state_nxt = S_RESP;
        end
      end

      S_RESP: begin
        if (!ovld_r || out_port.ready) begin
          ovld_nxt   = 1'b1;
          o_rd_nxt   = res_rd_r;
          o_err_nxt  = res_err_r;
          o_byte_nxt = res_byte_r;
          o_ov_nxt   = res_ov_r;
          o_last_nxt = res_last_r;
          state_nxt  = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      boot_r      <= 1'b1;
      phase_r     <= PH_HEADER;
      cursor_r    <= '0;
      blk_start_r <= '0;
      blk_words_r <= '0;
      byte_idx_r  <= '0;
      entry_r     <= '0;
      header_r    <= '0;
      ovld_r      <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      boot_r      <= boot_nxt;
      phase_r     <= phase_nxt;
      cursor_r    <= cursor_nxt;
      blk_start_r <= blk_start_nxt;
      blk_words_r <= blk_words_nxt;
      byte_idx_r  <= byte_idx_nxt;
      entry_r     <= entry_nxt;
      header_r    <= header_nxt;
      ovld_r      <= ovld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    act_r      <= act_nxt;
    addr_r     <= addr_nxt;
    val_r      <= val_nxt;
    allow_r    <= allow_nxt;
    res_rd_r   <= res_rd_nxt;
    res_err_r  <= res_err_nxt;
    res_byte_r <= res_byte_nxt;
    res_ov_r   <= res_ov_nxt;
    res_last_r <= res_last_nxt;
    o_rd_r     <= o_rd_nxt;
    o_err_r    <= o_err_nxt;
    o_byte_r   <= o_byte_nxt;
    o_ov_r     <= o_ov_nxt;
    o_last_r   <= o_last_nxt;
  end

  // one item at a time: an accepted word drops ready on the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> !in_port.ready)
    else $error("request side ready right after accepting a word");

  // the last-byte flag only rides on an actual image byte
  a_last_has_byte: assert property (@(posedge clk) disable iff (!rst_n)
    out_port.valid && out_port.image_last |-> out_port.out_valid)
    else $error("image_last without an image byte");

  // the store is only written by the clear sweep or a define
  a_store_write_src: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (state_r == S_CLR) || ((state_r == S_MCHK) && (act_r == oibe_pkg::ACT_DEFINE)))
    else $error("store written outside clear sweep or define");

  // run length never passes the block limit
  a_run_bound: assert property (@(posedge clk) disable iff (!rst_n)
    blk_words_r <= RUN_MAX)
    else $error("block run exceeds limit");

endmodule
